// ===== rtl/spiral_route_cipher_assert.svh =====
// assertion macros for the spiral route cipher checker
// depends on nothing; taken in by the checker with `include
`ifndef SPIRAL_ROUTE_CIPHER_ASSERT_SVH
`define SPIRAL_ROUTE_CIPHER_ASSERT_SVH

// plain property sampled on the rising clock, off while reset is low
`define SRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define SRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/src_pkg.sv =====
// shared types, constants and helpers of the spiral route cipher
// depends on nothing
package src_pkg;

  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 64;
  localparam int BUF_DEPTH = 4096;

  localparam int ADDR_W = $clog2(BUF_DEPTH);
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;
  localparam int SIZE_W = 7;
  localparam int BND_W  = 8;
  localparam int CHR_W  = 7;

  localparam logic [CHR_W-1:0] CHAR_X = 7'h58;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PULL  = 2'd1,
    KIND_START = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_CW   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HD_UP    = 2'd0,
    HD_RIGHT = 2'd1,
    HD_DOWN  = 2'd2,
    HD_LEFT  = 2'd3
  } heading_e;

  // walk position and progress, walker to top level
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             done;
    logic             last;
  } walk_status_t;

  // zero acts as one, large values saturate
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] max_v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // fold lower case letters onto upper case
  function automatic logic [7:0] to_upper(logic [7:0] c);
    logic [7:0] r;
    if (c >= CHAR_LA && c <= CHAR_LZ) begin
      r = c - CASE_OFS;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

// ===== rtl/spiral_route_cipher.sv =====
// spiral route cipher: usage notes
// Input channel (in_valid_i / in_stall_o) takes one request per accepted edge:
//   kind_i load stores char_in_i (upper-cased) if it is a letter A-Z and the
//   4096-letter buffer has room; pull emits the next spiral cell; start clears
//   the buffer and restarts the walk; the unused kind code is ignored.
// Output channel (out_valid_o / out_stall_i) carries cipher_char_o and
//   last_char_o, one request per pull while the walk has cells left.
// A result shows in the cycle after its pull is accepted, the time of
//   the letter buffer's registered read port.
// Throughput: one request per cycle while in_stall_o is low; the walker steps
//   once and the buffer is read once per pull.
// While a result waits under out_stall_i, in_stall_o is high and the input
//   channel holds; the result and its fields stay put until taken.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) are the user's to make while
//   idle, which the block does not enforce; one to a used index restarts the
//   walk, keeping stored letters; sizes of 0 act as 1, big ones saturate at 64.
// Reset: 1x1 grid, clockwise, empty buffer, walk at its start; the buffer
//   contents are not cleared, the letter count alone marks what is valid.
module spiral_route_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [7:0]                  char_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [src_pkg::CHR_W-1:0]   cipher_char_o,
  output logic                        last_char_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [src_pkg::SIZE_W-1:0]  cfg_data_i
);

  localparam int SIZE_W = src_pkg::SIZE_W;
  localparam int CNT_W  = src_pkg::CNT_W;
  localparam int ADDR_W = src_pkg::ADDR_W;
  localparam logic [SIZE_W-1:0] MAXC = SIZE_W'(src_pkg::MAX_COLS);
  localparam logic [SIZE_W-1:0] MAXR = SIZE_W'(src_pkg::MAX_ROWS);

  logic [SIZE_W-1:0]     cols_q, cols_d;
  logic [SIZE_W-1:0]     rows_q, rows_d;
  logic                  cw_q, cw_d;
  logic                  cfg_hit;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic                  pad_q, last_q;
  logic                  in_fire, pull_fire, start_fire, load_fire;
  logic [7:0]            upper;
  logic [CNT_W-1:0]      cell_idx;
  logic [src_pkg::CHR_W-1:0] rdata;
  src_pkg::walk_status_t wstat;

  // configuration decode
  always_comb begin
    cols_d  = cols_q;
    rows_d  = rows_q;
    cw_d    = cw_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        src_pkg::CFG_COLS: begin
          cols_d  = src_pkg::clamp_size(cfg_data_i, MAXC);
          cfg_hit = 1'b1;
        end
        src_pkg::CFG_ROWS: begin
          rows_d  = src_pkg::clamp_size(cfg_data_i, MAXR);
          cfg_hit = 1'b1;
        end
        src_pkg::CFG_CW: begin
          cw_d    = cfg_data_i[0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= SIZE_W'(1);
      rows_q <= SIZE_W'(1);
      cw_q   <= 1'b1;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
      cw_q   <= cw_d;
    end
  end

  // request decode
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign upper      = src_pkg::to_upper(char_in_i);
  assign load_fire  = in_fire && (kind_i == src_pkg::KIND_LOAD) &&
                      (upper >= src_pkg::CHAR_UA) && (upper <= src_pkg::CHAR_UZ) &&
                      (count_q < CNT_W'(src_pkg::BUF_DEPTH));
  assign start_fire = in_fire && (kind_i == src_pkg::KIND_START);
  assign pull_fire  = in_fire && (kind_i == src_pkg::KIND_PULL) && !wstat.done;

  // letter count
  always_comb begin
    count_d = count_q;
    if (start_fire) begin
      count_d = '0;
    end else if (load_fire) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // row-major cell index of the current spiral position
  assign cell_idx = CNT_W'({7'b0, wstat.row} * {6'b0, cols_q}) + CNT_W'(wstat.col);

  src_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_hit | start_fire),
    .step_i    (pull_fire),
    .cols_i    (cols_d),
    .rows_i    (rows_d),
    .cw_i      (cw_d),
    .status_o  (wstat)
  );

  src_letter_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (upper[src_pkg::CHR_W-1:0]),
    .re_i    (pull_fire),
    .raddr_i (cell_idx[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (pull_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pull_fire) begin
      pad_q  <= (cell_idx >= count_q);
      last_q <= wstat.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_char_o = pad_q ? src_pkg::CHAR_X : rdata;
  assign last_char_o   = last_q;

endmodule

// ===== rtl/src_letter_ram.sv =====
// letter buffer: single write port, single registered read port
// depends on src_pkg for depth and widths
module src_letter_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [src_pkg::ADDR_W-1:0]  waddr_i,
  input  logic [src_pkg::CHR_W-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [src_pkg::ADDR_W-1:0]  raddr_i,
  output logic [src_pkg::CHR_W-1:0]   rdata_o
);

  logic [src_pkg::CHR_W-1:0] mem [src_pkg::BUF_DEPTH];
  logic [src_pkg::CHR_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/src_walker.sv =====
// spiral walk: position, heading, shrinking bounds and cell count
// depends on src_pkg for types and widths
module src_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic                        step_i,
  input  logic [src_pkg::SIZE_W-1:0]  cols_i,
  input  logic [src_pkg::SIZE_W-1:0]  rows_i,
  input  logic                        cw_i,
  output src_pkg::walk_status_t       status_o
);

  localparam int CNT_W = src_pkg::CNT_W;
  localparam int BND_W = src_pkg::BND_W;
  localparam int COL_W = src_pkg::COL_W;
  localparam int ROW_W = src_pkg::ROW_W;
  localparam logic [src_pkg::SIZE_W-1:0] SIZE_ONE = src_pkg::SIZE_W'(1);

  logic [COL_W-1:0]         col_q, col_d;
  logic [ROW_W-1:0]         row_q, row_d;
  src_pkg::heading_e        hd_q, hd_d, hd_t;
  logic signed [BND_W-1:0]  top_q, top_d;
  logic signed [BND_W-1:0]  right_q, right_d;
  logic signed [BND_W-1:0]  bottom_q, bottom_d;
  logic signed [BND_W-1:0]  left_q, left_d;
  logic [CNT_W-1:0]         emitted_q, emitted_d;
  logic [CNT_W-1:0]         total;
  logic signed [BND_W-1:0]  col_s, row_s;

  // cells in the grid
  assign total = CNT_W'({7'b0, cols_i} * {7'b0, rows_i});
  assign col_s = $signed({{(BND_W-COL_W){1'b0}}, col_q});
  assign row_s = $signed({{(BND_W-ROW_W){1'b0}}, row_q});

  // next walk state: back to the start on restart, else turn at a bound, then move one cell
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    hd_d      = hd_q;
    hd_t      = hd_q;
    top_d     = top_q;
    right_d   = right_q;
    bottom_d  = bottom_q;
    left_d    = left_q;
    emitted_d = emitted_q;
    if (restart_i) begin
      col_d     = COL_W'(cols_i - SIZE_ONE);
      row_d     = '0;
      hd_d      = cw_i ? src_pkg::HD_DOWN : src_pkg::HD_LEFT;
      top_d     = -BND_W'(1);
      right_d   = $signed({1'b0, cols_i});
      bottom_d  = $signed({1'b0, rows_i});
      left_d    = -BND_W'(1);
      emitted_d = '0;
    end else if (step_i) begin
      emitted_d = emitted_q + CNT_W'(1);
      unique case (hd_q)
        src_pkg::HD_UP: begin
          if (row_s - BND_W'(1) == top_q) begin
            if (cw_i) begin
              hd_t = src_pkg::HD_RIGHT; left_d = left_q + BND_W'(1);
            end else begin
              hd_t = src_pkg::HD_LEFT; right_d = right_q - BND_W'(1);
            end
          end
        end
        src_pkg::HD_RIGHT: begin
          if (col_s + BND_W'(1) == right_q) begin
            if (cw_i) begin
              hd_t = src_pkg::HD_DOWN; top_d = top_q + BND_W'(1);
            end else begin
              hd_t = src_pkg::HD_UP; bottom_d = bottom_q - BND_W'(1);
            end
          end
        end
        src_pkg::HD_DOWN: begin
          if (row_s + BND_W'(1) == bottom_q) begin
            if (cw_i) begin
              hd_t = src_pkg::HD_LEFT; right_d = right_q - BND_W'(1);
            end else begin
              hd_t = src_pkg::HD_RIGHT; left_d = left_q + BND_W'(1);
            end
          end
        end
        src_pkg::HD_LEFT: begin
          if (col_s - BND_W'(1) == left_q) begin
            if (cw_i) begin
              hd_t = src_pkg::HD_UP; bottom_d = bottom_q - BND_W'(1);
            end else begin
              hd_t = src_pkg::HD_DOWN; top_d = top_q + BND_W'(1);
            end
          end
        end
        default: hd_t = hd_q;
      endcase
      hd_d = hd_t;
      unique case (hd_t)
        src_pkg::HD_UP:    row_d = row_q - ROW_W'(1);
        src_pkg::HD_RIGHT: col_d = col_q + COL_W'(1);
        src_pkg::HD_DOWN:  row_d = row_q + ROW_W'(1);
        src_pkg::HD_LEFT:  col_d = col_q - COL_W'(1);
        default:           col_d = col_q;
      endcase
    end
  end

  // walk registers, reset matches a one-by-one clockwise grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      hd_q      <= src_pkg::HD_DOWN;
      top_q     <= -BND_W'(1);
      right_q   <= BND_W'(1);
      bottom_q  <= BND_W'(1);
      left_q    <= -BND_W'(1);
      emitted_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      hd_q      <= hd_d;
      top_q     <= top_d;
      right_q   <= right_d;
      bottom_q  <= bottom_d;
      left_q    <= left_d;
      emitted_q <= emitted_d;
    end
  end

  // status toward the top level
  assign status_o.col  = col_q;
  assign status_o.row  = row_q;
  assign status_o.done = (emitted_q >= total);
  assign status_o.last = (emitted_q + CNT_W'(1) == total);

endmodule

// ===== rtl/src_checker.sv =====
// port-level checker for the spiral route cipher, bound to the top level
// depends on src_pkg and spiral_route_cipher_assert.svh
`include "spiral_route_cipher_assert.svh"

module src_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  kind_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [src_pkg::CHR_W-1:0]   cipher_char_o,
  input logic                        last_char_o
);

  logic in_fire;
  assign in_fire = in_valid_i & ~in_stall_o;

  // a stalled result stays offered
  `SRC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // a stalled result keeps its fields
  `SRC_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(cipher_char_o) && $stable(last_char_o), "result changed under stall")

  // every result is an upper case letter
  `SRC_ASSERT_IMP(a_letter, clk_i, rst_ni, out_valid_o, cipher_char_o >= src_pkg::CHAR_UA[src_pkg::CHR_W-1:0] && cipher_char_o <= src_pkg::CHAR_UZ[src_pkg::CHR_W-1:0], "result not a letter")

  // only a pull request makes a result
  `SRC_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, in_fire && (kind_i != src_pkg::KIND_PULL), !out_valid_o, "result without a pull")

endmodule

bind spiral_route_cipher src_checker u_src_checker (.*);

// ===== dv/spiral_cipher_monitor.sv =====
// request and result monitor for the spiral route cipher: keeps its own letter buffer
// and spiral walk, predicts each cipher letter and compares the results in order
// depends on src_pkg
module spiral_cipher_monitor
  import src_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        char_in_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [CHR_W-1:0]  cipher_char_i,
  input  logic              last_char_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       letters_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHR_W-1:0] letter;
    logic             last;
  } cipher_cell_t;

  cipher_cell_t cipher_q[$];
  logic [7:0]   letter_mem [BUF_DEPTH];
  int           letter_cnt;
  int           cells_done;
  int           n_cols;
  int           n_rows;
  logic         cw;
  int           col;
  int           row;
  int           b_top;
  int           b_right;
  int           b_bottom;
  int           b_left;
  heading_e     hd;
  int unsigned  fails;
  int unsigned  checked;

  // zero reads as one, oversize saturates
  function automatic int fit_size(logic [SIZE_W-1:0] v, int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // back to the top-right cell with the bounds just outside the grid
  function automatic void rewind_walk();
    cells_done = 0;
    col        = n_cols - 1;
    row        = 0;
    hd         = cw ? HD_DOWN : HD_LEFT;
    b_top      = -1;
    b_right    = n_cols;
    b_bottom   = n_rows;
    b_left     = -1;
  endfunction

  // letter under the current cell, then one step along the spiral
  function automatic cipher_cell_t next_cipher_cell();
    cipher_cell_t c;
    int           pos;
    c.letter = CHAR_X;
    if (col >= 0 && row >= 0 && col < n_cols && row < n_rows) begin
      pos = row * n_cols + col;
      if (pos < letter_cnt) c.letter = letter_mem[pos][CHR_W-1:0];
    end
    cells_done++;
    c.last = (cells_done == n_cols * n_rows);

    // turn where the next step would hit a bound, pulling in the bound just passed
    if (hd == HD_UP && row - 1 == b_top) begin
      if (cw) begin
        hd = HD_RIGHT;
        b_left++;
      end else begin
        hd = HD_LEFT;
        b_right--;
      end
    end else if (hd == HD_RIGHT && col + 1 == b_right) begin
      if (cw) begin
        hd = HD_DOWN;
        b_top++;
      end else begin
        hd = HD_UP;
        b_bottom--;
      end
    end else if (hd == HD_DOWN && row + 1 == b_bottom) begin
      if (cw) begin
        hd = HD_LEFT;
        b_right--;
      end else begin
        hd = HD_RIGHT;
        b_left++;
      end
    end else if (hd == HD_LEFT && col - 1 == b_left) begin
      if (cw) begin
        hd = HD_UP;
        b_bottom--;
      end else begin
        hd = HD_DOWN;
        b_top++;
      end
    end

    case (hd)
      HD_UP:    row--;
      HD_RIGHT: col++;
      HD_DOWN:  row++;
      default:  col--;
    endcase
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cipher_cell_t want;
    logic [7:0]   up;
    if (!rst_ni) begin
      cipher_q.delete();
      letter_cnt = 0;
      n_cols     = 1;
      n_rows     = 1;
      cw         = 1'b1;
      fails      = 0;
      checked    = 0;
      rewind_walk();
    end else begin
      // result side first, the oldest prediction belongs to it
      if (out_valid_i && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: cipher letter %h (last %b) with no pull waiting", $time,
                   cipher_char_i, last_char_i);
          fails++;
        end else begin
          want = cipher_q.pop_front();
          checked++;
          if (cipher_char_i !== want.letter) begin
            $display("%0t: cipher_char mismatch, expected %h actual %h", $time,
                     want.letter, cipher_char_i);
            fails++;
          end
          if (last_char_i !== want.last) begin
            $display("%0t: last_char mismatch, expected %b actual %b", $time,
                     want.last, last_char_i);
            fails++;
          end
        end
      end

      // accepted request
      if (in_valid_i && !in_stall_i) begin
        case (kind_i)
          KIND_LOAD: begin
            up = char_in_i;
            if (up >= CHAR_LA && up <= CHAR_LZ) up = up - CASE_OFS;
            if (up >= CHAR_UA && up <= CHAR_UZ && letter_cnt < BUF_DEPTH) begin
              letter_mem[letter_cnt] = up;
              letter_cnt++;
            end
          end
          KIND_PULL: begin
            if (cells_done < n_cols * n_rows) cipher_q.push_back(next_cipher_cell());
          end
          KIND_START: begin
            letter_cnt = 0;
            rewind_walk();
          end
          default: ;
        endcase
      end

      // writes to a used register index restart the walk, letters stay
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COLS: begin
            n_cols = fit_size(cfg_data_i, MAX_COLS);
            rewind_walk();
          end
          CFG_ROWS: begin
            n_rows = fit_size(cfg_data_i, MAX_ROWS);
            rewind_walk();
          end
          CFG_CW: begin
            cw = cfg_data_i[0];
            rewind_walk();
          end
          default: ;
        endcase
      end
    end
    pending_o         <= cipher_q.size();
    fail_count_o      <= fails;
    letters_checked_o <= checked;
  end

endmodule

// ===== dv/tb_spiral_route_cipher.sv =====
// top of the spiral route cipher testbench: clock, reset, request and register
// stimulus, result stall pattern and verdict; depends on src_pkg, the block
// and spiral_cipher_monitor
module tb_spiral_route_cipher;
  timeunit 1ns;
  timeprecision 1ps;
  import src_pkg::*;

  localparam int          ITEM_TARGET   = 1250;
  localparam int          PULL_CAP      = 260;
  localparam int          GAP_PCT       = 20;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          RX_JAM_CYCLES = 300;
  localparam int          FLOOD_LETTERS = 200;
  localparam int          FINAL_ROWS    = 4;
  localparam longint      RUN_LIMIT_NS  = 10_000_000;
  localparam logic [1:0]  KIND_NONE     = 2'd3;
  localparam logic [1:0]  CFG_NONE      = 2'd3;
  // lower a, Z, nul, all ones, chars just outside both letter ranges, high-bit a,
  // lower z, upper A
  localparam logic [87:0] PROBE_BYTES   = {8'h61, 8'h5A, 8'h00, 8'hFF, 8'h40, 8'h5B,
                                           8'h60, 8'h7B, 8'hE1, 8'h7A, 8'h41};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [1:0]        kind_i      = KIND_LOAD;
  logic [7:0]        char_in_i   = 8'h00;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CHR_W-1:0]  cipher_char_o;
  logic              last_char_o;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_idx_i   = CFG_COLS;
  logic [SIZE_W-1:0] cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned letters_checked;

  bit          steady     = 1'b0;
  bit          jam_rx     = 1'b0;
  bit          jam_served = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned reg_writes    = 0;
  int          geo_cols      = 1;
  int          geo_rows      = 1;

  spiral_route_cipher u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .char_in_i     (char_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cipher_char_o (cipher_char_o),
    .last_char_o   (last_char_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  spiral_cipher_monitor u_monitor (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .kind_i            (kind_i),
    .char_in_i         (char_in_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cipher_char_i     (cipher_char_o),
    .last_char_i       (last_char_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .letters_checked_o (letters_checked)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("spiral_route_cipher verification failed");
    $finish;
  end

  // result side: random stalls, one long hold-off while the sender keeps pulling
  initial begin : result_sink
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (jam_rx && !jam_served) begin
        jam_served = 1'b1;
        out_stall_i <= 1'b1;
        for (held = 0; held < RX_JAM_CYCLES; held++) @(posedge clk_i);
      end
      out_stall_i <= !steady && ($urandom_range(0, 99) < GAP_PCT);
    end
  end

  // one request, with random idle cycles ahead of it, held until taken
  task automatic offer_request(input logic [1:0] k, input logic [7:0] c);
    while (!steady && $urandom_range(0, 99) < GAP_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    char_in_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (k != KIND_NONE) requests_sent++;
  endtask

  // stop sending and wait until every predicted letter has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called while the block is idle
  task automatic set_register(input logic [1:0] idx, input logic [SIZE_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
    if (idx == CFG_COLS) geo_cols = (d == 0) ? 1 : ((d > MAX_COLS) ? MAX_COLS : int'(d));
    if (idx == CFG_ROWS) geo_rows = (d == 0) ? 1 : ((d > MAX_ROWS) ? MAX_ROWS : int'(d));
  endtask

  // mostly letters of either case, some raw bytes
  function automatic logic [7:0] message_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
    else if ($urandom_range(0, 1) == 1) b = CHAR_UA + 8'($urandom_range(0, 25));
    else b = CHAR_LA + 8'($urandom_range(0, 25));
    return b;
  endfunction

  // small grids mostly, now and then zero, full or oversize
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 8) return SIZE_W'($urandom_range(MAX_COLS + 1, 127));
    if (roll < 11) return SIZE_W'(MAX_COLS);
    if (roll < 25) return SIZE_W'($urandom_range(9, 20));
    return SIZE_W'($urandom_range(1, 8));
  endfunction

  // new geometry or direction; sometimes only a write to the unused index
  task automatic retune_grid();
    drain_results();
    if ($urandom_range(0, 5) == 0) begin
      set_register(CFG_NONE, SIZE_W'($urandom_range(0, 127)));
    end else begin
      if ($urandom_range(0, 3) != 0) set_register(CFG_COLS, pick_size());
      if ($urandom_range(0, 3) != 0) set_register(CFG_ROWS, pick_size());
      if ($urandom_range(0, 1) == 1) set_register(CFG_CW, SIZE_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin : stimulus
    int         cells;
    int         n_load;
    int         n_pull;
    logic [1:0] noise_kind;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty 1x1 grid after reset: one padding letter, then the walk is over
    offer_request(KIND_PULL, 8'h00);
    offer_request(KIND_PULL, 8'hFF);
    offer_request(KIND_NONE, CHAR_LA);

    // 3x2 counter-clockwise, bytes on both sides of each letter range
    drain_results();
    set_register(CFG_COLS, SIZE_W'(3));
    set_register(CFG_ROWS, SIZE_W'(2));
    set_register(CFG_CW, SIZE_W'(0));
    offer_request(KIND_START, 8'h00);
    for (int i = 10; i >= 0; i--) offer_request(KIND_LOAD, PROBE_BYTES[8*i +: 8]);
    repeat (7) offer_request(KIND_PULL, 8'h00);

    // oversize columns, zero rows, clockwise from a wide word; letters kept
    drain_results();
    set_register(CFG_COLS, SIZE_W'(127));
    set_register(CFG_ROWS, SIZE_W'(0));
    set_register(CFG_CW, SIZE_W'(127));
    repeat (3) offer_request(KIND_PULL, 8'h00);
    // unused index mid-walk leaves the walk where it is
    drain_results();
    set_register(CFG_NONE, SIZE_W'(42));
    repeat (2) offer_request(KIND_PULL, 8'h00);

    // random messages: mostly start, load, full walk; some partial walks and noise
    while (requests_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) retune_grid();
      cells = geo_cols * geo_rows;
      if ($urandom_range(0, 9) != 0) offer_request(KIND_START, message_byte());
      n_load = $urandom_range(0, ((cells < 200) ? cells : 200) + 2);
      repeat (n_load) offer_request(KIND_LOAD, message_byte());
      if ($urandom_range(0, 6) == 0) n_pull = $urandom_range(1, cells);
      else n_pull = cells + $urandom_range(0, 2);
      // large grids get a partial walk to keep the run short
      if (n_pull > PULL_CAP) n_pull = PULL_CAP;
      repeat (n_pull) begin
        if ($urandom_range(0, 11) == 0) begin
          noise_kind = ($urandom_range(0, 1) == 1) ? KIND_NONE : KIND_LOAD;
          offer_request(noise_kind, message_byte());
        end
        offer_request(KIND_PULL, message_byte());
      end
    end

    // full-width grid, partly padded, no idling, one long result hold-off
    drain_results();
    steady = 1'b1;
    set_register(CFG_COLS, SIZE_W'(MAX_COLS));
    set_register(CFG_ROWS, SIZE_W'(FINAL_ROWS));
    set_register(CFG_CW, SIZE_W'($urandom_range(0, 1)));
    offer_request(KIND_START, message_byte());
    repeat (FLOOD_LETTERS) begin
      if ($urandom_range(0, 1) == 1) offer_request(KIND_LOAD, CHAR_UA + 8'($urandom_range(0, 25)));
      else offer_request(KIND_LOAD, CHAR_LA + 8'($urandom_range(0, 25)));
    end
    jam_rx = 1'b1;
    repeat (MAX_COLS * FINAL_ROWS + 1) offer_request(KIND_PULL, message_byte());
    steady = 1'b0;

    drain_results();
    $display("run covered %0d requests and %0d register writes, grids up to 64 a side both ways",
             requests_sent, reg_writes);
    $display("%0d cipher letters compared, including a full-width walk under a long hold-off",
             letters_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("spiral_route_cipher verification clean");
    end else begin
      $display("spiral_route_cipher verification failed");
    end
    $finish;
  end

endmodule

// ===== spiral_route_cipher.f =====
+incdir+rtl
rtl/src_pkg.sv
rtl/src_letter_ram.sv
rtl/src_walker.sv
rtl/spiral_route_cipher.sv
rtl/src_checker.sv
dv/spiral_cipher_monitor.sv
dv/tb_spiral_route_cipher.sv
